[hw/rtl/jaos_pkg.sv]
// Shared types, character codes and key table for the JSON array object splitter.
`default_nettype none

package jaos_pkg;

    // Character codes the parser reacts to
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Quoted key "result" is eight characters long
    localparam int unsigned KEY_LEN = 8;
    localparam int unsigned KEY_PW  = 3;
    localparam logic [KEY_PW-1:0] KEY_LAST = 3'd7;

    // Depth counters are fixed at eight bits
    localparam int unsigned DEPTH_W = 8;

    // One result word
    typedef struct packed {
        logic       array_end;
        logic       object_truncated;
        logic       object_end;
        logic       byte_valid;
        logic [7:0] out_byte;
    } jaos_result_t;

    // Key character at a match position
    function automatic logic [7:0] key_char(input logic [KEY_PW-1:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_QUOTE;
            3'd1:    ch = 8'h72; // r
            3'd2:    ch = 8'h65; // e
            3'd3:    ch = 8'h73; // s
            3'd4:    ch = 8'h75; // u
            3'd5:    ch = 8'h6C; // l
            3'd6:    ch = 8'h74; // t
            default: ch = CH_QUOTE;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/jaos_parser.sv]
// Parse state registers and the per-byte step logic of the splitter.
`default_nettype none

module jaos_parser #(
    parameter int OBJ_MAX   = 512,
    parameter int DEPTH_MAX = 255
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step_en,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  start_of_stream,
    output jaos_pkg::jaos_result_t     result,
    output logic                       has_result
);

    localparam int CW = $clog2(OBJ_MAX);
    localparam logic [CW-1:0] CNT_CAP = CW'(OBJ_MAX - 1);
    localparam logic [jaos_pkg::DEPTH_W-1:0] DEPTH_LIM = jaos_pkg::DEPTH_W'(DEPTH_MAX);

    logic [jaos_pkg::KEY_PW-1:0]  key_pos_reg, key_pos_next;
    logic                         await_reg, await_next;
    logic                         in_array_reg, in_array_next;
    logic                         quote_open_reg, quote_open_next;
    logic                         esc_reg, esc_next;
    logic                         obj_open_reg, obj_open_next;
    logic [jaos_pkg::DEPTH_W-1:0] brace_reg, brace_next;
    logic [jaos_pkg::DEPTH_W-1:0] bracket_reg, bracket_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         dropped_reg, dropped_next;

    logic       do_pass;
    logic       close_chk;
    logic       keep;
    logic       obj_end;
    logic       trunc;
    logic       arr_end;
    logic       key_hit;
    logic [7:0] c;

    assign c = data_byte;

    // Step logic: follows one byte through the parse
    always_comb begin
        // start of stream clears everything before this byte
        key_pos_next    = start_of_stream ? '0 : key_pos_reg;
        await_next      = start_of_stream ? 1'b0 : await_reg;
        in_array_next   = start_of_stream ? 1'b0 : in_array_reg;
        quote_open_next = start_of_stream ? 1'b0 : quote_open_reg;
        esc_next        = start_of_stream ? 1'b0 : esc_reg;
        obj_open_next   = start_of_stream ? 1'b0 : obj_open_reg;
        brace_next      = start_of_stream ? '0 : brace_reg;
        bracket_next    = start_of_stream ? '0 : bracket_reg;
        count_next      = start_of_stream ? '0 : count_reg;
        dropped_next    = start_of_stream ? 1'b0 : dropped_reg;

        do_pass   = 1'b0;
        close_chk = 1'b0;
        keep      = 1'b0;
        obj_end   = 1'b0;
        trunc     = 1'b0;
        arr_end   = 1'b0;
        key_hit   = 1'b0;

        if (!in_array_next) begin
            // key hunt and wait for the opening bracket
            if (await_next && c == jaos_pkg::CH_LBRACKET) begin
                await_next      = 1'b0;
                in_array_next   = 1'b1;
                quote_open_next = 1'b0;
                esc_next        = 1'b0;
                obj_open_next   = 1'b0;
                brace_next      = '0;
                bracket_next    = jaos_pkg::DEPTH_W'(1);
                count_next      = '0;
                dropped_next    = 1'b0;
            end else if (await_next && (c inside {jaos_pkg::CH_SPACE, jaos_pkg::CH_TAB,
                                                  jaos_pkg::CH_LF, jaos_pkg::CH_CR,
                                                  jaos_pkg::CH_COLON})) begin
                await_next = 1'b1;
            end else begin
                if (await_next) begin
                    await_next   = 1'b0;
                    key_pos_next = '0;
                end
                key_hit = (c == jaos_pkg::key_char(key_pos_next));
                if (key_hit) begin
                    if (key_pos_next == jaos_pkg::KEY_LAST) begin
                        key_pos_next = '0;
                        await_next   = 1'b1;
                    end else begin
                        key_pos_next = key_pos_next + 1'b1;
                    end
                end else begin
                    key_pos_next = (c == jaos_pkg::CH_QUOTE) ? jaos_pkg::KEY_PW'(1) : '0;
                end
            end
        end else if (esc_next) begin
            esc_next = 1'b0;
            do_pass  = 1'b1;
        end else if (c == jaos_pkg::CH_BACKSLASH && quote_open_next) begin
            esc_next = 1'b1;
            do_pass  = 1'b1;
        end else if (c == jaos_pkg::CH_QUOTE) begin
            quote_open_next = !quote_open_next;
            do_pass         = 1'b1;
        end else if (quote_open_next) begin
            do_pass = 1'b1;
        end else if (c == jaos_pkg::CH_LBRACE) begin
            if (brace_next < DEPTH_LIM) begin
                brace_next = brace_next + 1'b1;
            end
            if (brace_next == jaos_pkg::DEPTH_W'(1) && !obj_open_next) begin
                obj_open_next = 1'b1;
                count_next    = '0;
                dropped_next  = 1'b0;
            end
            do_pass = 1'b1;
        end else if (c == jaos_pkg::CH_RBRACE) begin
            // stray closing brace at depth zero is ignored
            if (brace_next != '0) begin
                brace_next = brace_next - 1'b1;
                do_pass    = 1'b1;
                close_chk  = 1'b1;
            end
        end else if (c == jaos_pkg::CH_LBRACKET) begin
            if (bracket_next < DEPTH_LIM) begin
                bracket_next = bracket_next + 1'b1;
            end
            do_pass = 1'b1;
        end else if (c == jaos_pkg::CH_RBRACKET) begin
            if (bracket_next != '0) begin
                bracket_next = bracket_next - 1'b1;
            end
            if (bracket_next == '0) begin
                arr_end = 1'b1;
            end else begin
                do_pass = 1'b1;
            end
        end else begin
            do_pass = 1'b1;
        end

        // keep the byte if the object is open and under the cap
        if (do_pass && obj_open_next) begin
            if (count_next < CNT_CAP) begin
                count_next = count_next + 1'b1;
                keep       = 1'b1;
            end else begin
                dropped_next = 1'b1;
            end
        end

        // top-level object closed
        if (close_chk && brace_next == '0 && obj_open_next) begin
            obj_end       = 1'b1;
            trunc         = dropped_next;
            obj_open_next = 1'b0;
            count_next    = '0;
            dropped_next  = 1'b0;
        end

        // array closed: back to the key hunt from a clean state
        if (arr_end) begin
            keep            = 1'b0;
            key_pos_next    = '0;
            await_next      = 1'b0;
            in_array_next   = 1'b0;
            quote_open_next = 1'b0;
            esc_next        = 1'b0;
            obj_open_next   = 1'b0;
            brace_next      = '0;
            bracket_next    = '0;
            count_next      = '0;
            dropped_next    = 1'b0;
        end
    end

    // Result word
    always_comb begin
        result.out_byte         = keep ? c : 8'h00;
        result.byte_valid       = keep;
        result.object_end       = obj_end;
        result.object_truncated = obj_end & trunc;
        result.array_end        = arr_end;
        has_result              = keep | obj_end | arr_end;
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_pos_reg    <= '0;
            await_reg      <= 1'b0;
            in_array_reg   <= 1'b0;
            quote_open_reg <= 1'b0;
            esc_reg        <= 1'b0;
            obj_open_reg   <= 1'b0;
            brace_reg      <= '0;
            bracket_reg    <= '0;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
        end else if (step_en) begin
            key_pos_reg    <= key_pos_next;
            await_reg      <= await_next;
            in_array_reg   <= in_array_next;
            quote_open_reg <= quote_open_next;
            esc_reg        <= esc_next;
            obj_open_reg   <= obj_open_next;
            brace_reg      <= brace_next;
            bracket_reg    <= bracket_next;
            count_reg      <= count_next;
            dropped_reg    <= dropped_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/jaos_out_buf.sv]
// Result register with a skid stage so input is taken while output stalls.
`default_nettype none

module jaos_out_buf (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    input  wire jaos_pkg::jaos_result_t in_word,
    output logic                        in_ready,
    output logic                        out_valid,
    output jaos_pkg::jaos_result_t      out_word,
    input  wire logic                   out_ready
);

    logic                   main_valid_reg;
    logic                   skid_valid_reg;
    jaos_pkg::jaos_result_t main_reg;
    jaos_pkg::jaos_result_t skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

    // Control: main moves when empty or taken, skid catches a stalled word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !main_valid_reg) begin
            main_valid_reg <= skid_valid_reg | in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (out_ready || !main_valid_reg) begin
            main_reg <= skid_valid_reg ? skid_reg : in_word;
        end else if (in_valid && !skid_valid_reg) begin
            skid_reg <= in_word;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/json_array_object_splitter.sv]
// Top level: streams the objects of the "result" array out of JSON text.
//
//  channel  | ports    | tdata          | tuser                                     | tlast
//  ---------+----------+----------------+-------------------------------------------+-----------
//  input    | s_axis_* | data_byte[7:0] | start_of_stream                           | -
//  result   | m_axis_* | out_byte[7:0]  | byte_valid, object_truncated, array_end   | object_end
//
//  One byte is taken per cycle while s_axis_tready is high; result words are registered.
//  The parse step is a single layer of compares and counters between the parse
//  state and the result register; a skid stage keeps input flowing for one
//  stalled word, after which s_axis_tready drops until the result is taken.
//  aresetn is synchronous and clears parse state and both output stages.
`default_nettype none

module json_array_object_splitter #(
    parameter int OBJ_MAX   = 512,
    parameter int DEPTH_MAX = 255
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
    input  wire logic       s_axis_tuser,  // [0] start_of_stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
    output logic [2:0]      m_axis_tuser,  // [0] byte_valid [1] object_truncated [2] array_end
    output logic            m_axis_tlast   // object_end
);

    logic                   accept;
    logic                   has_result;
    logic                   buf_ready;
    jaos_pkg::jaos_result_t step_word;
    jaos_pkg::jaos_result_t out_word;

    assign s_axis_tready = buf_ready;
    assign accept        = s_axis_tvalid & buf_ready;

    // Parse step
    jaos_parser #(
        .OBJ_MAX   (OBJ_MAX),
        .DEPTH_MAX (DEPTH_MAX)
    ) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (accept),
        .data_byte       (s_axis_tdata),
        .start_of_stream (s_axis_tuser),
        .result          (step_word),
        .has_result      (has_result)
    );

    // Result register and skid
    jaos_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept & has_result),
        .in_word   (step_word),
        .in_ready  (buf_ready),
        .out_valid (m_axis_tvalid),
        .out_word  (out_word),
        .out_ready (m_axis_tready)
    );

    // Pack result word onto the stream
    assign m_axis_tdata = out_word.out_byte;
    assign m_axis_tuser = {out_word.array_end, out_word.object_truncated, out_word.byte_valid};
    assign m_axis_tlast = out_word.object_end;

endmodule

`default_nettype wire
